FILE: design/mftc_pkg.sv
// Shared types and constants for the median-filtered TDS conversion unit.
`timescale 1ns / 1ps
package mftc_pkg;
	localparam int WINDOW_DEF = 30;
	localparam int SAMPLE_W   = 10;
	localparam int TEMP_W     = 11;
	localparam int MV_W       = 13;
	localparam int PPM_W      = 16;
	localparam int DIV_NUM_W  = 28;
	localparam int DIV_DEN_W  = 11;
	localparam int CQ_W       = 20;

	localparam logic [TEMP_W-1:0] TEMP_RESET = 11'd250;
	localparam logic [DIV_NUM_W-1:0] CQ_MAX = 28'h00FFFFF;
	localparam logic signed [34:0] A_OFS = 35'sd1676804096;
	localparam logic signed [56:0] P_OFS = 57'sd85739 <<< 32;
	localparam logic [58:0] N_OFS = 59'd100 << 32;
	// ppm = (num >> 32) / 200; at or above 200 * 65536 the result clips
	localparam logic [26:0] PPM_SAT_NUM = 27'd13107200;
	// ceil(2^26 / 25), exact for dividends below 2^21
	localparam logic [21:0] PPM_RECIP = 22'd2684355;

	typedef struct packed {
		logic shift;
		logic load;
		logic cmp;
	} cell_ctl_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
	} div_rsp_t;
endpackage

FILE: design/mftc_cell.sv
// Window cell: holds one sample, rotates a copy around the ring and ranks its sample.
`timescale 1ns / 1ps
module mftc_cell #(
	parameter int CNT_W = 5,
	parameter int K_LO  = 14,
	parameter int K_HI  = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mftc_pkg::cell_ctl_t           ctl,
	input  logic [mftc_pkg::SAMPLE_W-1:0] shift_in,
	input  logic [mftc_pkg::SAMPLE_W-1:0] rot_in,
	output logic [mftc_pkg::SAMPLE_W-1:0] w,
	output logic [mftc_pkg::SAMPLE_W-1:0] r,
	output logic                          hit_lo,
	output logic                          hit_hi
);
	logic [mftc_pkg::SAMPLE_W-1:0] w_q;
	logic [mftc_pkg::SAMPLE_W-1:0] r_q;
	logic [CNT_W-1:0]              lt_q;
	logic [CNT_W-1:0]              le_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
		end else if (ctl.shift) begin
			w_q <= shift_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			r_q  <= w_q;
			lt_q <= '0;
			le_q <= '0;
		end else if (ctl.cmp) begin
			r_q <= rot_in;
			if (r_q < w_q) begin
				lt_q <= lt_q + CNT_W'(1);
			end
			if (r_q <= w_q) begin
				le_q <= le_q + CNT_W'(1);
			end
		end
	end

	assign w      = w_q;
	assign r      = r_q;
	assign hit_lo = (lt_q <= CNT_W'(K_LO)) && (le_q > CNT_W'(K_LO));
	assign hit_hi = (lt_q <= CNT_W'(K_HI)) && (le_q > CNT_W'(K_HI));
endmodule

FILE: design/mftc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mftc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mftc_pkg::div_req_t req,
	output mftc_pkg::div_rsp_t rsp
);
	localparam int NW = mftc_pkg::DIV_NUM_W;
	localparam int DW = mftc_pkg::DIV_DEN_W;
	localparam int CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

FILE: design/median_filtered_tds_conversion_unit.sv
// Top level: sample window, median ranking, compensation and ppm conversion.
//
// Input channel s_*: s_tuser[0] is the item kind (0 = store sample, 1 = report),
// s_tdata[9:0] the raw ADC sample. A sample item is stored in the cycle it is
// accepted and gives no result. A report item gives one result on m_*.
// Output channel m_*: m_tdata holds median code [9:0], millivolts [22:10] and
// ppm [38:23]; m_tuser[0] flags a ppm value clipped at 65535.
// cfg_we/cfg_data write the signed water temperature in tenths of a degree.
// A report first rotates the samples through the cell ring for ranking, then
// picks the median, runs the bit-serial compensation divider, takes six steps
// of multiplying and rounding for the cubic, scales to ppm and loads the output
// register. s_tready returns as the result is loaded, so a new report is taken
// only once the last one is through. Samples are taken one per cycle whenever
// no report is in progress.
// The result sits in an output register; while the receiver stalls, further
// samples are still accepted, and a following report waits at its end until
// the register is free.
// Reset clears the window to zeros, the rotation counter and the output valid, and
// sets the temperature to 25.0 C.
`timescale 1ns / 1ps
module median_filtered_tds_conversion_unit #(
	parameter int WINDOW = mftc_pkg::WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // sample[9:0]
	input  logic [0:0]  s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // median_code[9:0], voltage_millivolts[22:10], tds_ppm[38:23]
	output logic [0:0]  m_tuser,   // saturated
	input  logic        cfg_we,
	input  logic [10:0] cfg_data   // temperature_tenths
);
	localparam int SW    = mftc_pkg::SAMPLE_W;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int K_LO  = (WINDOW - 1) / 2;
	localparam int K_HI  = WINDOW / 2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROT, ST_SEL, ST_DIVS1, ST_DIV1, ST_MUL_A, ST_MUL_P0, ST_MUL_P1,
		ST_RND, ST_MUL_N0, ST_MUL_N1, ST_PPM, ST_OUT
	} state_t;

	state_t                          state_q;
	logic [CNT_W-1:0]                rot_cnt_q;
	logic [mftc_pkg::TEMP_W-1:0]     temp_q;
	mftc_pkg::cell_ctl_t             ctl;
	mftc_pkg::div_req_t              div_req;
	mftc_pkg::div_rsp_t              div_rsp;
	logic                            s_acc;
	logic                            out_load;

	logic [SW-1:0] w_arr [WINDOW];
	logic [SW-1:0] r_arr [WINDOW];
	logic [WINDOW-1:0] hit_lo;
	logic [WINDOW-1:0] hit_hi;
	logic [SW-1:0] val_lo;
	logic [SW-1:0] val_hi;

	logic [SW-1:0]                med_q;
	logic [mftc_pkg::MV_W-1:0]    mv_q;
	logic [mftc_pkg::CQ_W-1:0]    cq_q;
	logic signed [34:0]           a_q;
	logic signed [56:0]           p_q;
	logic [37:0]                  pr_q;
	logic [58:0]                  n_q;
	logic [mftc_pkg::PPM_W-1:0]   ppm_q;
	logic                         sat_q;

	logic signed [11:0]           d_full;
	logic [mftc_pkg::DIV_DEN_W-1:0] d;
	logic [22:0]                  mv_prod;
	logic [9:0]                   cq_half;
	logic signed [45:0]           pp;
	logic [47:0]                  np;
	logic [42:0]                  ppm_prod;

	assign s_acc    = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!m_tvalid || m_tready);

	assign ctl.shift = s_acc && !s_tuser[0];
	assign ctl.load  = s_acc && s_tuser[0];
	assign ctl.cmp   = (state_q == ST_ROT);

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		mftc_cell #(.CNT_W(CNT_W), .K_LO(K_LO), .K_HI(K_HI)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.shift_in ((i == 0) ? s_tdata[SW-1:0] : w_arr[(i + WINDOW - 1) % WINDOW]),
			.rot_in   (r_arr[(i + WINDOW - 1) % WINDOW]),
			.w        (w_arr[i]),
			.r        (r_arr[i]),
			.hit_lo   (hit_lo[i]),
			.hit_hi   (hit_hi[i])
		);
	end

	always_comb begin
		val_lo = '0;
		val_hi = '0;
		for (int i = 0; i < WINDOW; i++) begin
			val_lo = val_lo | (hit_lo[i] ? w_arr[i] : '0);
			val_hi = val_hi | (hit_hi[i] ? w_arr[i] : '0);
		end
	end

	mftc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign d_full   = 12'sd250 + {temp_q[10], temp_q};
	assign d        = (d_full < 12'sd1) ? 11'd1 : d_full[10:0];
	assign mv_prod  = 23'(med_q) * 23'd5000 + 23'd512;
	assign cq_half  = (state_q == ST_MUL_P0 || state_q == ST_MUL_N0) ? cq_q[9:0] : cq_q[19:10];
	assign pp       = a_q * $signed({1'b0, cq_half});
	assign np       = pr_q * cq_half;
	// below the clip point (num >> 35) fits in 21 bits; divide it by 25
	assign ppm_prod = 43'(n_q[55:35]) * 43'(mftc_pkg::PPM_RECIP);

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = 28'(med_q) * 28'd160000 + 28'(d >> 1);
		div_req.den   = d;
		case (state_q)
			ST_DIVS1: begin
				div_req.start = 1'b1;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SEL: med_q <= SW'(({1'b0, val_lo} + {1'b0, val_hi}) >> 1);
			ST_DIVS1: mv_q <= mv_prod[22:10];
			ST_DIV1: begin
				if (div_rsp.quo > mftc_pkg::CQ_MAX) begin
					cq_q <= mftc_pkg::CQ_MAX[mftc_pkg::CQ_W-1:0];
				end else begin
					cq_q <= div_rsp.quo[mftc_pkg::CQ_W-1:0];
				end
			end
			ST_MUL_A: a_q <= $signed({1'b0, 34'(34'(cq_q) * 34'd13342)}) - mftc_pkg::A_OFS;
			ST_MUL_P0: p_q <= {{11{pp[45]}}, pp} + mftc_pkg::P_OFS;
			ST_MUL_P1: p_q <= p_q + {pp[45], pp, 10'b0};
			ST_RND: pr_q <= 38'((p_q[53:0] + 54'd32768) >> 16);
			ST_MUL_N0: n_q <= 59'(np);
			ST_MUL_N1: n_q <= n_q + {1'b0, np, 10'b0} + mftc_pkg::N_OFS;
			ST_PPM: begin
				if (n_q[58:32] >= mftc_pkg::PPM_SAT_NUM) begin
					ppm_q <= 16'hFFFF;
					sat_q <= 1'b1;
				end else begin
					ppm_q <= ppm_prod[41:26];
					sat_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rot_cnt_q <= '0;
			temp_q    <= mftc_pkg::TEMP_RESET;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
			m_tuser   <= '0;
		end else begin
			if (cfg_we) begin
				temp_q <= cfg_data;
			end
			if (m_tvalid && m_tready && !out_load) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					rot_cnt_q <= '0;
					if (s_acc && s_tuser[0]) begin
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					rot_cnt_q <= rot_cnt_q + CNT_W'(1);
					if (rot_cnt_q == CNT_W'(WINDOW - 1)) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL:    state_q <= ST_DIVS1;
				ST_DIVS1:  state_q <= ST_DIV1;
				ST_DIV1:   if (div_rsp.done) state_q <= ST_MUL_A;
				ST_MUL_A:  state_q <= ST_MUL_P0;
				ST_MUL_P0: state_q <= ST_MUL_P1;
				ST_MUL_P1: state_q <= ST_RND;
				ST_RND:    state_q <= ST_MUL_N0;
				ST_MUL_N0: state_q <= ST_MUL_N1;
				ST_MUL_N1: state_q <= ST_PPM;
				ST_PPM:    state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {1'b0, ppm_q, mv_q, med_q};
						m_tuser  <= sat_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_sample_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && !s_tuser[0]) |=> (w_arr[0] == $past(s_tdata[SW-1:0])))
		else $error("sample not stored in first cell");

	a_rot_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT && rot_cnt_q == CNT_W'(WINDOW - 1)) |=> (state_q == ST_SEL))
		else $error("rotation did not end after one full turn");

	a_rank_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEL) |-> ((|hit_lo) && (|hit_hi)))
		else $error("no cell holds the middle rank");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[38:23] == 16'hFFFF))
		else $error("saturation flag without clipped ppm");
endmodule

FILE: tb/sv/tb_top.sv
// Testbench for the median-filtered TDS conversion unit: random stream traffic checked by a predictor.
`timescale 1ns / 1ps
module tb_top;
	typedef struct {
		logic [9:0]  median;
		logic [12:0] millivolts;
		logic [15:0] ppm;
		logic        clipped;
	} tds_report_t;

	class tds_scoreboard;
		logic [9:0]        window [mftc_pkg::WINDOW_DEF];
		int                wpos;
		logic signed [10:0] temp_tenths;
		tds_report_t       reports_due [$];
		int                errors;
		int                reports_seen;

		function new();
			foreach (window[i]) window[i] = '0;
			wpos = 0;
			temp_tenths = mftc_pkg::TEMP_RESET;
			errors = 0;
			reports_seen = 0;
		endfunction

		function void set_temp(logic [10:0] v);
			temp_tenths = v;
		endfunction

		function tds_report_t convert();
			int          sorted [mftc_pkg::WINDOW_DEF];
			int          d;
			bit [63:0]   med, cq, a, p, pr, num, q;
			tds_report_t r;
			foreach (window[i]) sorted[i] = window[i];
			sorted.sort();
			med = (sorted[mftc_pkg::WINDOW_DEF/2] + sorted[mftc_pkg::WINDOW_DEF/2 - 1]) / 2;
			r.median = med[9:0];
			r.millivolts = 13'((med * 5000 + 512) / 1024);
			d = 250 + int'(temp_tenths);
			if (d < 1) d = 1;
			cq = (med * 160000 + 64'(d / 2)) / 64'(d);
			if (cq > 64'hFFFFF) cq = 64'hFFFFF;
			a = 64'd13342 * cq - (64'd25586 << 16);
			p = a * cq + (64'd85739 << 32);
			pr = (p + (64'd1 << 15)) >> 16;
			num = pr * cq + (64'd100 << 32);
			q = num / (64'd200 << 32);
			r.clipped = q > 64'd65535;
			r.ppm = r.clipped ? 16'hFFFF : q[15:0];
			return r;
		endfunction

		function void note_item(logic kind, logic [9:0] sample);
			if (kind == 1'b0) begin
				window[wpos] = sample;
				wpos = (wpos + 1) % mftc_pkg::WINDOW_DEF;
			end else begin
				reports_due.push_back(convert());
			end
		endfunction

		function void check_report(logic [39:0] data, logic clip);
			tds_report_t e;
			if (reports_due.size() == 0) begin
				$display("%0t: unexpected report, actual %h", $time, data);
				errors++;
				return;
			end
			e = reports_due.pop_front();
			reports_seen++;
			if (data[9:0] !== e.median) begin
				$display("%0t: median exp %0d act %0d", $time, e.median, data[9:0]);
				errors++;
			end
			if (data[22:10] !== e.millivolts) begin
				$display("%0t: mV exp %0d act %0d", $time, e.millivolts, data[22:10]);
				errors++;
			end
			if (data[38:23] !== e.ppm) begin
				$display("%0t: ppm exp %0d act %0d", $time, e.ppm, data[38:23]);
				errors++;
			end
			if (clip !== e.clipped) begin
				$display("%0t: sat exp %0b act %0b", $time, e.clipped, clip);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [10:0] cfg_data = '0;

	tds_scoreboard sb = new();
	bit  calm = 1'b0;
	int  stall_left = 0;
	int  quiet_cycles = 0;
	int  items_sent = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	median_filtered_tds_conversion_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always @(negedge clk) begin
		if (calm || !arst_n) begin
			m_tready = arst_n;
		end else if (stall_left > 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			m_tready = 1'b0;
		end else begin
			m_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_report(m_tdata, m_tuser[0]);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= 3000) begin
			$display("Watchdog: no progress for %0d cycles", quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_item(logic kind, logic [9:0] sample);
		if (!calm && $urandom_range(0, 7) == 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = {6'd0, sample};
		do @(posedge clk); while (!s_tready);
		sb.note_item(kind, sample);
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.reports_due.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_temp(logic [10:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_temp(v);
	endtask

	task automatic random_run(int count);
		repeat (count) begin
			if ($urandom_range(0, 7) == 0)
				send_item(1'b1, 10'($urandom_range(0, 1023)));
			else if ($urandom_range(0, 5) == 0)
				send_item(1'b0, $urandom_range(0, 1) ? 10'h3FF : 10'h000);
			else
				send_item(1'b0, 10'($urandom_range(0, 1023)));
		end
	endtask

	initial begin
		logic [10:0] temps [8];
		temps = '{11'sd250, -11'sd100, 11'sd1000, -11'sd250, 11'h400, 11'sd1023,
			11'sd37, 11'sd0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fresh window, extremes, report with junk in the sample field
		send_item(1'b1, 10'h3FF);
		send_item(1'b0, 10'h3FF);
		send_item(1'b1, 10'h000);
		repeat (15) send_item(1'b0, 10'h3FF);
		send_item(1'b1, 10'h2AA);
		send_item(1'b0, 10'h000);
		send_item(1'b0, 10'h155);
		send_item(1'b1, 10'h155);
		drain();

		foreach (temps[i]) begin
			write_temp(temps[i]);
			random_run(200);
			send_item(1'b1, 10'h000);
			drain();
		end
		write_temp(11'($urandom_range(0, 1100)) - 11'sd100);
		calm = 1'b1;
		random_run(150);
		drain();

		$display("Sent %0d items, checked %0d reports over 10 temperature settings.",
			items_sent, sb.reports_seen);
		if (sb.errors == 0 && sb.reports_due.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
